FILE: src/pect_pkg.sv
`default_nettype none
package pect_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int MIN_POLY = 3;

    localparam logic [1:0] ST_TRI = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_NOEAR = 2'd2;
    localparam logic [1:0] ST_OVF = 2'd3;

    localparam logic REG_WINDING = 1'b0;

    localparam logic [1:0] TGT_A = 2'd0;
    localparam logic [1:0] TGT_B = 2'd1;
    localparam logic [1:0] TGT_C = 2'd2;
    localparam logic [1:0] TGT_P = 2'd3;

    localparam logic [1:0] X_CVX = 2'd0;
    localparam logic [1:0] X_ABP = 2'd1;
    localparam logic [1:0] X_BCP = 2'd2;
    localparam logic [1:0] X_CAP = 2'd3;
endpackage
`default_nettype wire

FILE: src/pect_ram.sv
`default_nettype none
module pect_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/polygon_ear_clip_triangulator_core.sv
// Loading accepts one vertex per cycle while ready; the closing vertex starts the
// clipping walk, or a status-only result on overflow or on too few vertices.
// The walk is data dependent: each ear candidate is tested for convexity, then every
// other remaining vertex against it, serialised by the single vertex memory read port.
// Clipping an ear shifts later list entries down; triangles are read back for output.
// Synchronous active-low reset clears the sequencer, vertex counter, output flags and
// winding register; the memories are not cleared.
`default_nettype none
module polygon_ear_clip_triangulator_core
    import pect_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         i_vertex_valid,
    output logic                              o_vertex_ready,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_x,
    input  wire logic signed [COORD_BITS-1:0] i_vertex_y,
    input  wire logic                         i_vertex_last,
    output logic                              o_result_valid,
    input  wire logic                         i_result_ready,
    output logic signed [COORD_BITS-1:0]      o_tri_ax,
    output logic signed [COORD_BITS-1:0]      o_tri_ay,
    output logic signed [COORD_BITS-1:0]      o_tri_bx,
    output logic signed [COORD_BITS-1:0]      o_tri_by,
    output logic signed [COORD_BITS-1:0]      o_tri_cx,
    output logic signed [COORD_BITS-1:0]      o_tri_cy,
    output logic      [1:0]                   o_result_status,
    output logic                              o_result_last
);
    localparam int CB = COORD_BITS;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;
    localparam int KW = 3 * AW;

    typedef enum logic [18:0] {
        S_LOAD = 19'h00001,
        S_INIT = 19'h00002,
        S_FREM = 19'h00004,
        S_FCRD = 19'h00008,
        S_FCAP = 19'h00010,
        S_XD   = 19'h00020,
        S_XM   = 19'h00040,
        S_XS   = 19'h00080,
        S_XE   = 19'h00100,
        S_KCHK = 19'h00200,
        S_TRIW = 19'h00400,
        S_MVR  = 19'h00800,
        S_MVW  = 19'h01000,
        S_ET   = 19'h02000,
        S_ETD  = 19'h04000,
        S_EA   = 19'h08000,
        S_EB   = 19'h10000,
        S_EC   = 19'h20000,
        S_OWT  = 19'h40000
    } t_state;

    t_state r_state;
    logic [CNTW-1:0] r_cnt, r_len, r_k;
    logic r_ovf, r_wind, r_final, r_neg, r_posf;
    logic [AW-1:0] r_pos, r_init, r_j, r_ntri, r_e;
    logic [AW-1:0] r_ia, r_ib, r_ic;
    logic [1:0] r_tgt, r_xsel;
    logic [KW-1:0] r_pk;
    logic signed [CB-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_px, r_py;
    logic signed [DW-1:0] r_d0, r_d1, r_d2, r_d3;
    logic signed [PW-1:0] r_m0, r_m1;
    logic signed [XW-1:0] r_cr;
    logic r_oval, r_olast;
    logic [1:0] r_ostat;
    logic signed [CB-1:0] r_oax, r_oay, r_obx, r_oby, r_ocx, r_ocy;

    logic crd_we, rem_we, tri_we;
    logic [AW-1:0] crd_waddr, crd_raddr, rem_waddr, rem_raddr, tri_waddr, tri_raddr;
    logic [2*CB-1:0] crd_rdata;
    logic [AW-1:0] rem_wdata, rem_rdata;
    logic [KW-1:0] tri_wdata, tri_rdata;

    logic [AW-1:0] pp, np;
    logic [CNTW-1:0] pos_w;
    logic signed [CB-1:0] ux, uy, vx, vy, wx, wy;
    logic cr_neg, cr_pos, corner_cvx, cvr_neg, cvr_pos;
    logic [CNTW-1:0] n_now;
    logic in_xfer;

    assign pos_w = CNTW'(r_pos);
    assign pp = (r_pos == '0) ? AW'(r_len - 1'b1) : r_pos - 1'b1;
    assign np = ((pos_w + 1'b1) >= r_len) ? '0 : AW'(pos_w + 1'b1);
    assign in_xfer = i_vertex_valid && o_vertex_ready;
    assign n_now = (r_cnt < CNTW'(MAX_VERTICES)) ? r_cnt + 1'b1 : r_cnt;

    always_comb begin
        ux = r_ax; uy = r_ay; vx = r_bx; vy = r_by; wx = r_cx; wy = r_cy;
        case (r_xsel)
            X_CVX: begin
                ux = r_ax; uy = r_ay; vx = r_bx; vy = r_by; wx = r_cx; wy = r_cy;
            end
            X_ABP: begin
                ux = r_ax; uy = r_ay; vx = r_bx; vy = r_by; wx = r_px; wy = r_py;
            end
            X_BCP: begin
                ux = r_bx; uy = r_by; vx = r_cx; vy = r_cy; wx = r_px; wy = r_py;
            end
            X_CAP: begin
                ux = r_cx; uy = r_cy; vx = r_ax; vy = r_ay; wx = r_px; wy = r_py;
            end
            default: begin
                ux = r_ax; uy = r_ay; vx = r_bx; vy = r_by; wx = r_cx; wy = r_cy;
            end
        endcase
    end

    assign cr_neg = r_cr[XW-1];
    assign cr_pos = !r_cr[XW-1] && (r_cr != '0);
    assign corner_cvx = r_wind ? cr_pos : cr_neg;
    assign cvr_neg = r_neg || cr_neg;
    assign cvr_pos = r_posf || cr_pos;

    always_comb begin
        crd_we = (r_state == S_LOAD) && in_xfer && (r_cnt < CNTW'(MAX_VERTICES));
        crd_waddr = r_cnt[AW-1:0];
        crd_raddr = '0;
        case (r_state)
            S_FCRD: crd_raddr = rem_rdata;
            S_ETD:  crd_raddr = tri_rdata[KW-1 -: AW];
            S_EA:   crd_raddr = r_pk[KW-AW-1 -: AW];
            S_EB:   crd_raddr = r_pk[AW-1:0];
            default: crd_raddr = '0;
        endcase
    end

    always_comb begin
        rem_we = 1'b0;
        rem_waddr = r_init;
        rem_wdata = r_init;
        rem_raddr = '0;
        case (r_state)
            S_INIT: rem_we = 1'b1;
            S_MVW: begin
                rem_we = 1'b1;
                rem_waddr = r_j;
                rem_wdata = rem_rdata;
            end
            S_MVR: rem_raddr = r_j + 1'b1;
            S_FREM: begin
                case (r_tgt)
                    TGT_A: rem_raddr = r_final ? AW'(0) : pp;
                    TGT_B: rem_raddr = r_final ? AW'(1) : r_pos;
                    TGT_C: rem_raddr = r_final ? AW'(2) : np;
                    TGT_P: rem_raddr = r_k[AW-1:0];
                    default: rem_raddr = '0;
                endcase
            end
            default: rem_raddr = '0;
        endcase
    end

    assign tri_we = (r_state == S_TRIW);
    assign tri_waddr = r_ntri;
    assign tri_wdata = {r_ia, r_ib, r_ic};
    assign tri_raddr = r_e;

    pect_ram #(.WIDTH(2 * CB), .DEPTH(MAX_VERTICES)) u_crd (
        .i_clk(i_clk), .i_we(crd_we), .i_waddr(crd_waddr),
        .i_wdata({i_vertex_x, i_vertex_y}), .i_raddr(crd_raddr), .o_rdata(crd_rdata)
    );

    pect_ram #(.WIDTH(AW), .DEPTH(MAX_VERTICES)) u_rem (
        .i_clk(i_clk), .i_we(rem_we), .i_waddr(rem_waddr),
        .i_wdata(rem_wdata), .i_raddr(rem_raddr), .o_rdata(rem_rdata)
    );

    pect_ram #(.WIDTH(KW), .DEPTH(MAX_VERTICES)) u_tri (
        .i_clk(i_clk), .i_we(tri_we), .i_waddr(tri_waddr),
        .i_wdata(tri_wdata), .i_raddr(tri_raddr), .o_rdata(tri_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_WINDING)) begin
            r_wind <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {31'd0, r_wind};

    always_ff @(posedge i_clk) begin
        r_d0 <= DW'(vx) - DW'(ux);
        r_d1 <= DW'(vy) - DW'(uy);
        r_d2 <= DW'(wx) - DW'(ux);
        r_d3 <= DW'(wy) - DW'(uy);
        r_m0 <= r_d0 * r_d3;
        r_m1 <= r_d1 * r_d2;
        r_cr <= XW'(r_m0) - XW'(r_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt <= '0;
            r_ovf <= 1'b0;
            r_oval <= 1'b0;
            r_olast <= 1'b0;
            r_final <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (r_cnt < CNTW'(MAX_VERTICES)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_vertex_last) begin
                            r_cnt <= '0;
                            r_ovf <= 1'b0;
                            r_len <= n_now;
                            r_init <= '0;
                            r_ntri <= '0;
                            r_pos <= '0;
                            r_tgt <= TGT_A;
                            r_final <= (n_now == CNTW'(MIN_POLY));
                            if (r_ovf || (r_cnt == CNTW'(MAX_VERTICES))) begin
                                r_ostat <= ST_OVF;
                                r_state <= S_OWT;
                                r_oval <= 1'b1;
                                r_olast <= 1'b1;
                            end else if (n_now < CNTW'(MIN_POLY)) begin
                                r_ostat <= ST_FEW;
                                r_state <= S_OWT;
                                r_oval <= 1'b1;
                                r_olast <= 1'b1;
                            end else begin
                                r_state <= S_INIT;
                            end
                            r_oax <= '0; r_oay <= '0; r_obx <= '0;
                            r_oby <= '0; r_ocx <= '0; r_ocy <= '0;
                        end
                    end
                end
                S_INIT: begin
                    r_init <= r_init + 1'b1;
                    if (CNTW'(r_init) == r_len - 1'b1) begin
                        r_state <= S_FREM;
                    end
                end
                S_FREM: r_state <= S_FCRD;
                S_FCRD: begin
                    case (r_tgt)
                        TGT_A: r_ia <= rem_rdata;
                        TGT_B: r_ib <= rem_rdata;
                        TGT_C: r_ic <= rem_rdata;
                        default: r_ia <= r_ia;
                    endcase
                    r_state <= S_FCAP;
                end
                S_FCAP: begin
                    case (r_tgt)
                        TGT_A: begin
                            r_ax <= crd_rdata[2*CB-1:CB];
                            r_ay <= crd_rdata[CB-1:0];
                            r_tgt <= TGT_B;
                            r_state <= S_FREM;
                        end
                        TGT_B: begin
                            r_bx <= crd_rdata[2*CB-1:CB];
                            r_by <= crd_rdata[CB-1:0];
                            r_tgt <= TGT_C;
                            r_state <= S_FREM;
                        end
                        TGT_C: begin
                            r_cx <= crd_rdata[2*CB-1:CB];
                            r_cy <= crd_rdata[CB-1:0];
                            r_xsel <= X_CVX;
                            r_state <= r_final ? S_TRIW : S_XD;
                        end
                        default: begin
                            r_px <= crd_rdata[2*CB-1:CB];
                            r_py <= crd_rdata[CB-1:0];
                            r_xsel <= X_ABP;
                            r_neg <= 1'b0;
                            r_posf <= 1'b0;
                            r_state <= S_XD;
                        end
                    endcase
                end
                S_XD: r_state <= S_XM;
                S_XM: r_state <= S_XS;
                S_XS: r_state <= S_XE;
                S_XE: begin
                    case (r_xsel)
                        X_CVX: begin
                            if (corner_cvx) begin
                                r_k <= '0;
                                r_state <= S_KCHK;
                            end else if (pos_w + 1'b1 == r_len) begin
                                r_ostat <= ST_NOEAR;
                                r_oax <= '0; r_oay <= '0; r_obx <= '0;
                                r_oby <= '0; r_ocx <= '0; r_ocy <= '0;
                                r_oval <= 1'b1;
                                r_olast <= 1'b1;
                                r_state <= S_OWT;
                            end else begin
                                r_pos <= r_pos + 1'b1;
                                r_tgt <= TGT_A;
                                r_state <= S_FREM;
                            end
                        end
                        X_ABP, X_BCP: begin
                            r_neg <= cvr_neg;
                            r_posf <= cvr_pos;
                            r_xsel <= r_xsel + 1'b1;
                            r_state <= S_XD;
                        end
                        default: begin
                            if (!(cvr_neg && cvr_pos)) begin
                                if (pos_w + 1'b1 == r_len) begin
                                    r_ostat <= ST_NOEAR;
                                    r_oax <= '0; r_oay <= '0; r_obx <= '0;
                                    r_oby <= '0; r_ocx <= '0; r_ocy <= '0;
                                    r_oval <= 1'b1;
                                    r_olast <= 1'b1;
                                    r_state <= S_OWT;
                                end else begin
                                    r_pos <= r_pos + 1'b1;
                                    r_tgt <= TGT_A;
                                    r_state <= S_FREM;
                                end
                            end else begin
                                r_k <= r_k + 1'b1;
                                r_state <= S_KCHK;
                            end
                        end
                    endcase
                end
                S_KCHK: begin
                    if (r_k == r_len) begin
                        r_state <= S_TRIW;
                    end else if ((r_k[AW-1:0] == pp) || (r_k[AW-1:0] == r_pos)
                                 || (r_k[AW-1:0] == np)) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_tgt <= TGT_P;
                        r_state <= S_FREM;
                    end
                end
                S_TRIW: begin
                    r_ntri <= r_ntri + 1'b1;
                    r_j <= r_pos;
                    if (r_final) begin
                        r_e <= '0;
                        r_state <= S_ET;
                    end else begin
                        r_state <= S_MVR;
                    end
                end
                S_MVR: begin
                    if (CNTW'(r_j) + 1'b1 < r_len) begin
                        r_state <= S_MVW;
                    end else begin
                        r_len <= r_len - 1'b1;
                        r_pos <= '0;
                        r_tgt <= TGT_A;
                        r_final <= (r_len - 1'b1 == CNTW'(MIN_POLY));
                        r_state <= S_FREM;
                    end
                end
                S_MVW: begin
                    r_j <= r_j + 1'b1;
                    r_state <= S_MVR;
                end
                S_ET: r_state <= S_ETD;
                S_ETD: begin
                    r_pk <= tri_rdata;
                    r_state <= S_EA;
                end
                S_EA: begin
                    r_oax <= crd_rdata[2*CB-1:CB];
                    r_oay <= crd_rdata[CB-1:0];
                    r_state <= S_EB;
                end
                S_EB: begin
                    r_obx <= crd_rdata[2*CB-1:CB];
                    r_oby <= crd_rdata[CB-1:0];
                    r_state <= S_EC;
                end
                S_EC: begin
                    r_ocx <= crd_rdata[2*CB-1:CB];
                    r_ocy <= crd_rdata[CB-1:0];
                    r_ostat <= ST_TRI;
                    r_olast <= (r_e == r_ntri - 1'b1);
                    r_oval <= 1'b1;
                    r_state <= S_OWT;
                end
                S_OWT: begin
                    if (i_result_ready) begin
                        r_oval <= 1'b0;
                        if (r_olast) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_e <= r_e + 1'b1;
                            r_state <= S_ET;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_vertex_ready = (r_state == S_LOAD);
    assign o_result_valid = r_oval;
    assign o_result_last = r_olast;
    assign o_result_status = r_ostat;
    assign o_tri_ax = r_oax;
    assign o_tri_ay = r_oay;
    assign o_tri_bx = r_obx;
    assign o_tri_by = r_oby;
    assign o_tri_cx = r_ocx;
    assign o_tri_cy = r_ocy;

    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (r_state == S_OWT))
        else $error("Result valid outside the output wait state.");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vertex_ready |-> !o_result_valid)
        else $error("Vertex input open while a result is pending.");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_status != ST_TRI)) |->
        (o_result_last && (o_tri_ax == '0) && (o_tri_cy == '0)))
        else $error("Status-only result carries coordinates or is not last.");

    a_len_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRIW) |-> (r_len >= CNTW'(MIN_POLY)))
        else $error("Triangle recorded with fewer than three vertices left.");
endmodule
`default_nettype wire
